@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during rst
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, quiet during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/psl_pkg.sv @@
// Types, constants and codes of the priority sorted list
package psl_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int IDX1_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PRIO_W = 4;
  localparam int TAG_W  = 16;
  localparam int POS_W  = 6;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(10);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LIST   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_LISTED   = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

@@ hw/rtl/psl_intf.sv @@
// Request and response channel interfaces
interface psl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [psl_pkg::PRIO_W-1:0]  priority_req;
  logic [psl_pkg::TAG_W-1:0]   tag;

  modport source (output valid, output kind, output priority_req, output tag, input ready);
  modport sink (input valid, input kind, input priority_req, input tag, output ready);
endinterface

interface psl_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [psl_pkg::POS_W-1:0]   position;
  logic [psl_pkg::PRIO_W-1:0]  entry_priority;
  logic [psl_pkg::TAG_W-1:0]   entry_tag;
  logic                        last;

  modport source (output valid, output status, output position, output entry_priority,
                  output entry_tag, output last, input ready);
  modport sink (input valid, input status, input position, input entry_priority,
                input entry_tag, input last, output ready);
endinterface

@@ hw/rtl/priority_sorted_list_top.sv @@
// Priority sorted list: top level with entry memory and control sequencer
//
// req channel: one word per command. kind 0 inserts (priority_req, tag),
//   kind 1 lists the stored entries. ready is high only while idle.
// rsp channel: registered output word. An insert answers one word
//   (inserted with rank, or full). A list emits count words in ascending
//   priority, equal priorities in arrival order, last on the final one; an
//   empty list emits one empty word.
// Sequence: an insert compares the new entry with each stored entry above
//   it, moving every higher one up by a read and a write through the
//   single entry RAM; landing at the head skips the final compare. A list
//   reads each entry from the RAM, then loads it into the output word.
//   Full and empty answers go straight to the response load. ready rises
//   as the final word of a command loads.
// Reset: clears the entry count and the sequencer; the RAM keeps junk,
//   never read below the count.
// Stall: when rsp is not taken the sequencer holds its word and the RAM
//   read address, so nothing is lost or repeated.
`include "assert_macros.svh"

module priority_sorted_list_top (
  input logic        clk,
  input logic        rst,
  psl_in_if.sink     req,
  psl_out_if.source  rsp
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_LST_RD  = 6'b001000,
    S_LST_OUT = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t                           state;
  logic [psl_pkg::CNT_W-1:0]        count;
  logic [psl_pkg::IDX_W-1:0]        ins_idx;
  logic [psl_pkg::IDX_W-1:0]        lst_idx;
  logic [psl_pkg::PRIO_W-1:0]       new_prio;
  logic [psl_pkg::TAG_W-1:0]        new_tag;
  psl_pkg::status_t                 stg_status;
  logic [psl_pkg::POS_W-1:0]        stg_pos;

  logic                             out_valid;
  psl_pkg::status_t                 out_status;
  logic [psl_pkg::POS_W-1:0]        out_pos;
  logic [psl_pkg::PRIO_W-1:0]       out_prio;
  logic [psl_pkg::TAG_W-1:0]        out_tag;
  logic                             out_last;

  logic                             we;
  logic [psl_pkg::IDX_W-1:0]        raddr;
  psl_pkg::entry_t                  wdata;
  psl_pkg::entry_t                  rdata;
  psl_pkg::entry_t                  new_entry;
  logic [psl_pkg::PRIO_W-1:0]       req_prio;
  logic                             out_free;
  logic                             out_load;
  logic                             move_up;
  logic                             lst_last;
  logic [psl_pkg::POS_W-1:0]        ins_pos;
  logic [psl_pkg::POS_W-1:0]        lst_pos;

  psl_ram #(
    .WIDTH ($bits(psl_pkg::entry_t)),
    .DEPTH (psl_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ins_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.position   = out_pos;
  assign rsp.entry_priority = out_prio;
  assign rsp.entry_tag  = out_tag;
  assign rsp.last       = out_last;

  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = out_free && ((state == S_LST_OUT) || (state == S_RESP));
  assign new_entry = '{prio: new_prio, tag: new_tag};
  assign move_up   = (state == S_INS_CMP) && (rdata.prio > new_prio);
  assign ins_pos   = psl_pkg::POS_W'(psl_pkg::IDX1_W'(ins_idx) + psl_pkg::IDX1_W'(1));
  assign lst_pos   = psl_pkg::POS_W'(psl_pkg::IDX1_W'(lst_idx) + psl_pkg::IDX1_W'(1));
  assign lst_last  = (psl_pkg::CNT_W'(lst_idx) + psl_pkg::CNT_W'(1)) == count;

  always_comb begin
    if (req.priority_req < psl_pkg::PRIO_MIN) begin
      req_prio = psl_pkg::PRIO_MIN;
    end else if (req.priority_req > psl_pkg::PRIO_MAX) begin
      req_prio = psl_pkg::PRIO_MAX;
    end else begin
      req_prio = req.priority_req;
    end
  end

  always_comb begin
    we    = ((state == S_INS_RD) && (ins_idx == '0)) || (state == S_INS_CMP);
    wdata = move_up ? rdata : new_entry;
    raddr = (state == S_INS_RD) ? (ins_idx - psl_pkg::IDX_W'(1)) : lst_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req.valid) begin
          if (req.kind == psl_pkg::KIND_LIST) begin
            lst_idx <= '0;
            if (count == '0) begin
              stg_status <= psl_pkg::ST_EMPTY;
              stg_pos    <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_LST_RD;
            end
          end else if (count == psl_pkg::CNT_W'(psl_pkg::DEPTH)) begin
            stg_status <= psl_pkg::ST_FULL;
            stg_pos    <= '0;
            state      <= S_RESP;
          end else begin
            new_prio <= req_prio;
            new_tag  <= req.tag;
            ins_idx  <= count[psl_pkg::IDX_W-1:0];
            state    <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (ins_idx == '0) begin
            count      <= count + psl_pkg::CNT_W'(1);
            stg_status <= psl_pkg::ST_INSERTED;
            stg_pos    <= ins_pos;
            state      <= S_RESP;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (move_up) begin
            ins_idx <= ins_idx - psl_pkg::IDX_W'(1);
            state   <= S_INS_RD;
          end else begin
            count      <= count + psl_pkg::CNT_W'(1);
            stg_status <= psl_pkg::ST_INSERTED;
            stg_pos    <= ins_pos;
            state      <= S_RESP;
          end
        end
        S_LST_RD: begin
          state <= S_LST_OUT;
        end
        S_LST_OUT: if (out_free) begin
          out_status <= psl_pkg::ST_LISTED;
          out_pos    <= lst_pos;
          out_prio   <= rdata.prio;
          out_tag    <= rdata.tag;
          out_last   <= lst_last;
          if (lst_last) begin
            state <= S_IDLE;
          end else begin
            lst_idx <= lst_idx + psl_pkg::IDX_W'(1);
            state   <= S_LST_RD;
          end
        end
        S_RESP: if (out_free) begin
          out_status <= stg_status;
          out_pos    <= stg_pos;
          out_prio   <= '0;
          out_tag    <= '0;
          out_last   <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NOW(a_count_bound, 1'b1, count <= psl_pkg::CNT_W'(psl_pkg::DEPTH), "count above depth")
  `ASSERT_NOW(a_write_in_insert, we, (state == S_INS_RD) || (state == S_INS_CMP), "stray RAM write")
  `ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state != S_IDLE, "accept left idle")
  `ASSERT_NEXT(a_count_step, state != S_INS_RD && state != S_INS_CMP, $stable(count), "count moved")

endmodule

@@ hw/rtl/psl_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module psl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/tb_priority_sorted_list_top.sv @@
// Self-checking testbench: sorted priority list inserts and in-order listings
`timescale 1ns / 1ps

module tb_priority_sorted_list_top;
  import psl_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } rsp_word_t;

  typedef struct packed {
    kind_t               kind;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    tag;
    logic                typed;
    rsp_word_t           answer;
  } cmd_row_t;

  localparam int N_OPENING = 15;
  localparam int PHASE_ITEMS = 120;

  logic clk;
  logic rst;

  psl_in_if  req_if ();
  psl_out_if rsp_if ();

  priority_sorted_list_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  entry_t    sorted_entries[$];
  rsp_word_t answers_due[$];
  int        idle_pct;
  int        stall_pct;
  int        failures;
  logic      row_typed;
  rsp_word_t row_answer;

  cmd_row_t opening_cmds [N_OPENING] = '{
    '{KIND_LIST,   4'd0,  16'h0000, 1'b1, '{ST_EMPTY,    6'd0, 4'd0, 16'h0000, 1'b1}},
    '{KIND_INSERT, 4'd0,  16'h0000, 1'b1, '{ST_INSERTED, 6'd1, 4'd0, 16'h0000, 1'b1}},
    '{KIND_INSERT, 4'd15, 16'hFFFF, 1'b1, '{ST_INSERTED, 6'd2, 4'd0, 16'h0000, 1'b1}},
    '{KIND_INSERT, 4'd10, 16'h1234, 1'b0, '0},
    '{KIND_INSERT, 4'd1,  16'hA5A5, 1'b0, '0},
    '{KIND_INSERT, 4'd10, 16'h5A5A, 1'b0, '0},
    '{KIND_INSERT, 4'd5,  16'h0F0F, 1'b0, '0},
    '{KIND_INSERT, 4'd11, 16'hF0F0, 1'b0, '0},
    '{KIND_INSERT, 4'd1,  16'h0001, 1'b0, '0},
    '{KIND_INSERT, 4'd9,  16'h8000, 1'b0, '0},
    '{KIND_INSERT, 4'd2,  16'h7FFF, 1'b0, '0},
    '{KIND_LIST,   4'd0,  16'h0000, 1'b0, '0},
    '{KIND_INSERT, 4'd14, 16'h0000, 1'b0, '0},
    '{KIND_INSERT, 4'd3,  16'hFFFE, 1'b0, '0},
    '{KIND_LIST,   4'd7,  16'hFFFF, 1'b0, '0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_word_t make_word(status_t st, int pos, logic [PRIO_W-1:0] pr,
                                          logic [TAG_W-1:0] tg, logic lst);
    rsp_word_t w;
    w.status   = st;
    w.position = POS_W'(pos);
    w.prio     = pr;
    w.tag      = tg;
    w.last     = lst;
    return w;
  endfunction

  function automatic void list_answers(kind_t kind, logic [PRIO_W-1:0] prio,
                                       logic [TAG_W-1:0] tag, output rsp_word_t words[$]);
    logic [PRIO_W-1:0] pr;
    int                at;
    entry_t            e;
    words = {};
    if (kind == KIND_INSERT) begin
      if (sorted_entries.size() >= DEPTH) begin
        words.push_back(make_word(ST_FULL, 0, '0, '0, 1'b1));
      end else begin
        pr = (prio < PRIO_MIN) ? PRIO_MIN : (prio > PRIO_MAX) ? PRIO_MAX : prio;
        at = 0;
        while (at < sorted_entries.size() && sorted_entries[at].prio <= pr) at++;
        e.prio = pr;
        e.tag  = tag;
        sorted_entries.insert(at, e);
        words.push_back(make_word(ST_INSERTED, at + 1, '0, '0, 1'b1));
      end
    end else if (sorted_entries.size() == 0) begin
      words.push_back(make_word(ST_EMPTY, 0, '0, '0, 1'b1));
    end else begin
      foreach (sorted_entries[i]) begin
        words.push_back(make_word(ST_LISTED, i + 1, sorted_entries[i].prio,
                                  sorted_entries[i].tag, i == sorted_entries.size() - 1));
      end
    end
  endfunction

  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    rsp_word_t words[$];
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = make_word(status_t'(rsp_if.status), rsp_if.position, rsp_if.entry_priority,
                        rsp_if.entry_tag, rsp_if.last);
        if (answers_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected word: status %0d pos %0d prio %0d tag %h last %0d",
                     got.status, got.position, got.prio, got.tag, got.last);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.prio !== want.prio || got.tag !== want.tag || got.last !== want.last) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: exp status %0d pos %0d prio %0d tag %h last %0d, got %0d %0d %0d %h %0d",
                       want.status, want.position, want.prio, want.tag, want.last,
                       got.status, got.position, got.prio, got.tag, got.last);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        list_answers(kind_t'(req_if.kind), req_if.priority_req, req_if.tag, words);
        if (row_typed) begin
          answers_due.push_back(row_answer);
        end else begin
          foreach (words[i]) answers_due.push_back(words[i]);
        end
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(kind_t kind, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag,
                           logic typed, rsp_word_t answer);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid        = 1'b1;
    req_if.kind         = kind;
    req_if.priority_req = prio;
    req_if.tag          = tag;
    row_typed           = typed;
    row_answer          = answer;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    kind_t             kind;
    logic [PRIO_W-1:0] prio;
    int                insert_pct;
    insert_pct = (sorted_entries.size() >= DEPTH) ? 60 : 35;
    kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_LIST;
    prio = ($urandom_range(99) < 80) ? PRIO_W'($urandom_range(10, 1))
                                     : PRIO_W'($urandom_range(15));
    send_word(kind, prio, TAG_W'($urandom), 1'b0, '0);
  endtask

  initial begin
    rst                 = 1'b1;
    clk                 = 1'b0;
    failures            = 0;
    idle_pct            = 0;
    stall_pct           = 0;
    row_typed           = 1'b0;
    row_answer          = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = 1'b0;
    req_if.priority_req = '0;
    req_if.tag          = '0;
    rsp_if.ready        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_cmds[i]) begin
      send_word(opening_cmds[i].kind, opening_cmds[i].prio, opening_cmds[i].tag,
                opening_cmds[i].typed, opening_cmds[i].answer);
    end

    stall_pct = 72;
    repeat (PHASE_ITEMS) send_random_word();
    stall_pct = 0;
    idle_pct  = 72;
    repeat (PHASE_ITEMS) send_random_word();
    stall_pct = 6;
    idle_pct  = 6;
    repeat (PHASE_ITEMS) send_random_word();
    stall_pct = 0;
    idle_pct  = 0;
    repeat (PHASE_ITEMS) send_random_word();

    req_if.valid = 1'b0;
    for (int n = 0; answers_due.size() != 0 && n < 100000; n++) @(posedge clk);
    repeat (80) @(posedge clk);

    if (failures == 0 && answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/psl_pkg.sv
hw/rtl/psl_intf.sv
hw/rtl/psl_ram.sv
hw/rtl/priority_sorted_list_top.sv
tb/sv/tb_priority_sorted_list_top.sv
